/* hdl/gb5_pkg.sv */
`default_nettype none

package gb5_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int KERNEL_SIZE  = 5;
    localparam int HALF_K       = KERNEL_SIZE / 2;
    localparam int LINES        = KERNEL_SIZE - 1;

    localparam int NUM_CH       = 4;
    localparam int CH_W         = 8;
    localparam int PIX_W        = NUM_CH * CH_W;
    localparam int TDATA_W      = PIX_W;
    localparam int LINE_W       = LINES * PIX_W;

    localparam int DIM_W        = 11;
    localparam int CFG_IDX_W    = 2;

    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int OROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int EFF_W_W      = $clog2(MAX_WIDTH + 1);
    localparam int EFF_H_W      = $clog2(MAX_HEIGHT + 1);
    localparam int POS_W        = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);

    localparam int WEIGHT_W     = 3;
    localparam int SUM_SHIFT    = 8;
    // one row of taps weighs 16 in total
    localparam int HSUM_W       = CH_W + 4;
    localparam int VSUM_W       = CH_W + SUM_SHIFT;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef logic [NUM_CH-1:0][CH_W-1:0]   pixel_t;
    typedef pixel_t [LINES-1:0]            line_word_t;
    typedef pixel_t [KERNEL_SIZE-1:0]      column_t;
    typedef logic [NUM_CH-1:0][HSUM_W-1:0] hsum_t;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed
    {
        logic                   emit;
        logic                   last;
        logic [KERNEL_SIZE-1:0] col_mask;
        logic [KERNEL_SIZE-1:0] row_mask;
    } tap_ctrl_t;

    // binomial weights 1 4 6 4 1
    function automatic logic [WEIGHT_W-1:0] binom_weight(input int idx);
        logic [WEIGHT_W-1:0] w;
        case (idx)
            0, 4:    w = WEIGHT_W'(1);
            1, 3:    w = WEIGHT_W'(4);
            2:       w = WEIGHT_W'(6);
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [EFF_W_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
        logic [EFF_W_W-1:0] r;
        if (v == '0)
            r = EFF_W_W'(1);
        else if (int'(v) > MAX_WIDTH)
            r = EFF_W_W'(MAX_WIDTH);
        else
            r = EFF_W_W'(v);
        return r;
    endfunction

    function automatic logic [EFF_H_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
        logic [EFF_H_W-1:0] r;
        if (v == '0)
            r = EFF_H_W'(1);
        else if (int'(v) > MAX_HEIGHT)
            r = EFF_H_W'(MAX_HEIGHT);
        else
            r = EFF_H_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/gb5_ram.sv */
`default_nettype none

module gb5_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire              clk,
    input  wire              wr_en,
    input  wire [ADDR_W-1:0] wr_addr,
    input  wire [WIDTH-1:0]  wr_data,
    input  wire              rd_en,
    input  wire [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/gaussian_blur_5x5_stream.sv */
// channel  dir  payload
// s_axis   in   tdata red, green, blue, alpha; tuser opcode (1 = drain)
// m_axis   out  tdata red, green, blue, alpha; tlast frame end
// cfg      in   index 0 image width, index 1 image height; always ready
//
// a pixel per clock unless m_axis stalls, set by the single line-store read and write-back
// a result leaves after the transfer that completes its window (2*W+2 items later)
// async active-low reset clears control only; line store is never cleared, rows above
// the frame are masked out of the sum
// stage valids collapse bubbles, so input stalls only when every stage is full
`default_nettype none

module gaussian_blur_5x5_stream (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire [gb5_pkg::TDATA_W-1:0]    s_axis_tdata,   // red, green, blue, alpha
    input  wire                           s_axis_tuser,   // opcode
    output logic                          m_axis_tvalid,
    input  wire                           m_axis_tready,
    output logic [gb5_pkg::TDATA_W-1:0]   m_axis_tdata,   // red, green, blue, alpha
    output logic                          m_axis_tlast,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [gb5_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [gb5_pkg::DIM_W-1:0]      cfg_data
);

    import gb5_pkg::*;

    localparam logic [POS_W-1:0] RESET_FRAME_PX = POS_W'(RESET_WIDTH * RESET_HEIGHT);

    // configuration and raster counters
    logic [EFF_W_W-1:0] eff_w_reg, eff_w_next;
    logic [EFF_H_W-1:0] eff_h_reg, eff_h_next;
    logic [POS_W-1:0]   frame_px_reg, frame_px_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   emitted_reg, emitted_next;
    logic [COL_W-1:0]   in_col_reg, in_col_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [OROW_W-1:0]  out_row_reg, out_row_next;

    logic [POS_W-1:0]   lag;
    logic               cfg_write;
    logic               restart;
    logic               accept;
    logic               in_frame;
    logic               drop;
    logic               take;
    logic               emit_now;
    logic               last_now;
    logic               in_col_last;
    logic               out_col_last;
    tap_ctrl_t          ctrl_in;

    // pipeline control
    logic               v1_reg, v2_reg, v3_reg, ov_reg;
    logic               out_ready, r3, r2, r1;
    logic               s1_move, s2_move;

    // stage payload
    pixel_t             pix1_reg;
    logic [COL_W-1:0]   addr1_reg;
    tap_ctrl_t          ctrl1_reg;
    tap_ctrl_t          ctrl2_reg;
    logic               fwd1_reg;
    line_word_t         fwd_data_reg;
    column_t            win_reg [KERNEL_SIZE];
    hsum_t              hsum_next [KERNEL_SIZE];
    hsum_t              hsum3_reg [KERNEL_SIZE];
    logic [KERNEL_SIZE-1:0] row_mask3_reg;
    logic               last3_reg;
    pixel_t             out_pix_next;
    pixel_t             out_pix_reg;
    logic               out_last_reg;

    // line store
    line_word_t         ram_rd_data;
    line_word_t         ram_wr_data;
    line_word_t         old_lines;
    column_t            column_in;
    logic               ram_wr_en;
    logic               ram_rd_en;
    logic [COL_W-1:0]   ram_wr_addr;
    logic [COL_W-1:0]   ram_rd_addr;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign out_ready = !ov_reg || m_axis_tready;
    assign r3        = !v3_reg || out_ready;
    assign r2        = !v2_reg || !ctrl2_reg.emit || r3;
    assign r1        = !v1_reg || r2;
    assign s1_move   = v1_reg && r2;
    assign s2_move   = v2_reg && ctrl2_reg.emit && r3;

    assign s_axis_tready = r1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign lag          = POS_W'({eff_w_reg, 1'b0}) + POS_W'(2);
    assign in_frame     = pos_reg < frame_px_reg;
    assign drop         = in_frame && (s_axis_tuser == OP_DRAIN);
    assign take         = accept && !drop;
    assign emit_now     = (pos_reg >= lag) && (emitted_reg < frame_px_reg);
    assign last_now     = emit_now && ((emitted_reg + POS_W'(1)) == frame_px_reg);
    assign in_col_last  = (EFF_W_W'(in_col_reg) + EFF_W_W'(1)) == eff_w_reg;
    assign out_col_last = (EFF_W_W'(out_col_reg) + EFF_W_W'(1)) == eff_w_reg;

    // tap masks for the pixel that leaves with this transfer
    always_comb
    begin
        int col_off;
        int row_off;
        ctrl_in.emit = emit_now;
        ctrl_in.last = last_now;
        for (int j = 0; j < KERNEL_SIZE; j++)
        begin
            // window slot j holds the column and row at offset HALF_K - j
            col_off = int'(out_col_reg) + HALF_K - j;
            row_off = int'(out_row_reg) + HALF_K - j;
            ctrl_in.col_mask[j] = (col_off >= 0) && (col_off < int'(eff_w_reg));
            ctrl_in.row_mask[j] = (row_off >= 0) && (row_off < int'(eff_h_reg));
        end
    end

    always_comb
    begin
        eff_w_next   = eff_w_reg;
        eff_h_next   = eff_h_reg;
        pos_next     = pos_reg;
        emitted_next = emitted_reg;
        in_col_next  = in_col_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        restart      = 1'b0;

        if (take)
        begin
            pos_next    = pos_reg + POS_W'(1);
            in_col_next = in_col_last ? '0 : in_col_reg + COL_W'(1);
            if (emit_now)
            begin
                emitted_next = emitted_reg + POS_W'(1);
                if (out_col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
                if (last_now)
                begin
                    restart = 1'b1;
                end
            end
        end

        if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    eff_w_next = clamp_width(cfg_data);
                    restart    = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    eff_h_next = clamp_height(cfg_data);
                    restart    = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (restart)
        begin
            pos_next     = '0;
            emitted_next = '0;
            in_col_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end

        frame_px_next = POS_W'(eff_w_next) * POS_W'(eff_h_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg    <= EFF_W_W'(RESET_WIDTH);
            eff_h_reg    <= EFF_H_W'(RESET_HEIGHT);
            frame_px_reg <= RESET_FRAME_PX;
            pos_reg      <= '0;
            emitted_reg  <= '0;
            in_col_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
        end
        else
        begin
            eff_w_reg    <= eff_w_next;
            eff_h_reg    <= eff_h_next;
            frame_px_reg <= frame_px_next;
            pos_reg      <= pos_next;
            emitted_reg  <= emitted_next;
            in_col_reg   <= in_col_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
        end
    end

    // column read-modify-write: new pixel on top, oldest row drops out
    assign ram_rd_en   = take;
    assign ram_rd_addr = in_col_reg;
    assign ram_wr_en   = s1_move;
    assign ram_wr_addr = addr1_reg;
    assign old_lines   = fwd1_reg ? fwd_data_reg : ram_rd_data;

    always_comb
    begin
        column_in[0] = pix1_reg;
        for (int i = 1; i < KERNEL_SIZE; i++)
        begin
            column_in[i] = old_lines[i-1];
        end
        for (int i = 0; i < LINES; i++)
        begin
            ram_wr_data[i] = column_in[i];
        end
    end

    gb5_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // horizontal pass per window row
    always_comb
    begin
        logic [HSUM_W-1:0] acc;
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                acc = '0;
                for (int j = 0; j < KERNEL_SIZE; j++)
                begin
                    if (ctrl2_reg.col_mask[j])
                    begin
                        acc = acc + HSUM_W'(binom_weight(j)) * HSUM_W'(win_reg[j][i][ch]);
                    end
                end
                hsum_next[i][ch] = acc;
            end
        end
    end

    // vertical pass and scale by 1/256
    always_comb
    begin
        logic [VSUM_W-1:0] vacc;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            vacc = '0;
            for (int i = 0; i < KERNEL_SIZE; i++)
            begin
                if (row_mask3_reg[i])
                begin
                    vacc = vacc + VSUM_W'(binom_weight(i)) * VSUM_W'(hsum3_reg[i][ch]);
                end
            end
            out_pix_next[ch] = vacc[VSUM_W-1:SUM_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            ov_reg   <= 1'b0;
            fwd1_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= take;
            end
            if (take)
            begin
                fwd1_reg <= ram_wr_en && (ram_wr_addr == ram_rd_addr);
            end
            if (r2)
            begin
                v2_reg <= s1_move;
            end
            if (r3)
            begin
                v3_reg <= s2_move;
            end
            if (out_ready)
            begin
                ov_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix1_reg     <= pixel_t'(s_axis_tdata);
            addr1_reg    <= in_col_reg;
            ctrl1_reg    <= ctrl_in;
            fwd_data_reg <= ram_wr_data;
        end
        if (s1_move)
        begin
            ctrl2_reg  <= ctrl1_reg;
            win_reg[0] <= column_in;
            for (int j = 1; j < KERNEL_SIZE; j++)
            begin
                win_reg[j] <= win_reg[j-1];
            end
        end
        if (s2_move)
        begin
            hsum3_reg     <= hsum_next;
            row_mask3_reg <= ctrl2_reg.row_mask;
            last3_reg     <= ctrl2_reg.last;
        end
        if (out_ready && v3_reg)
        begin
            out_pix_reg  <= out_pix_next;
            out_last_reg <= last3_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg < frame_px_reg)
        else $error("emitted count reached frame size without restart");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_col_reg < eff_w_reg)
        else $error("input column beyond row width");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && ram_rd_en && (ram_wr_addr == ram_rd_addr)) |-> (eff_w_reg == EFF_W_W'(1)))
        else $error("line store read and write collide on a row wider than one pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && ctrl1_reg.emit) |-> (ctrl1_reg.col_mask[HALF_K] && ctrl1_reg.row_mask[HALF_K]))
        else $error("centre tap masked on an emitted pixel");
`endif

endmodule

`default_nettype wire

/* bench/gaussian_blur_5x5_stream_tb.sv */
`timescale 1ns / 1ps

module gaussian_blur_5x5_stream_tb;

    import gb5_pkg::*;

    localparam int RING_DEPTH    = 4 * MAX_WIDTH + 5;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [KERNEL_SIZE-1:0][3:0] BINOMIAL = {4'd1, 4'd4, 4'd6, 4'd4, 4'd1};

    typedef enum
    {
        FILL_RANDOM,
        FILL_WHITE,
        FILL_BLACK
    } pixel_fill_t;

    typedef enum
    {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_RARE
    } stall_mode_t;

    typedef struct
    {
        opcode_t op;
        pixel_t  px;
    } stream_item_t;

    typedef struct packed
    {
        logic   frame_end;
        pixel_t px;
    } blur_result_t;

    typedef struct
    {
        logic [CFG_IDX_W-1:0] index;
        logic [DIM_W-1:0]     value;
    } reg_write_t;

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata   = '0;
    logic                 s_axis_tuser   = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [DIM_W-1:0]     cfg_data       = '0;

    // blur predictor state
    pixel_t           line_mem [RING_DEPTH];
    logic [DIM_W-1:0] width_reg  = DIM_W'(RESET_WIDTH);
    logic [DIM_W-1:0] height_reg = DIM_W'(RESET_HEIGHT);
    int               in_row     = 0;
    int               in_col     = 0;
    int               emitted    = 0;

    stream_item_t pixel_queue [$];
    reg_write_t   reg_queue [$];
    blur_result_t expected_blur [$];
    stream_item_t item_on_bus;
    blur_result_t predicted;
    reg_write_t   write_on_bus;
    blur_result_t wanted;
    pixel_t       got;

    int          items_pending = 0;
    int          writes_pending = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    stall_mode_t stall_mode = STALL_NONE;

    gaussian_blur_5x5_stream DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int effective_dim(input logic [DIM_W-1:0] v, input int limit);
        if (v == '0)
            return 1;
        if (int'(v) > limit)
            return limit;
        return int'(v);
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
                                           input logic [DIM_W-1:0] value);
        if (index == REG_IMAGE_WIDTH || index == REG_IMAGE_HEIGHT)
        begin
            if (index == REG_IMAGE_WIDTH)
                width_reg = value;
            else
                height_reg = value;
            in_row  = 0;
            in_col  = 0;
            emitted = 0;
        end
    endfunction

    function automatic bit predict_blur(input stream_item_t item, output blur_result_t res);
        int w, h, frame_px, lag, pos, r, c, ry, cx, wt;
        int sum [NUM_CH];
        pixel_t tap;
        w        = effective_dim(width_reg, MAX_WIDTH);
        h        = effective_dim(height_reg, MAX_HEIGHT);
        frame_px = w * h;
        lag      = 2 * w + 2;
        pos      = in_row * w + in_col;
        res      = '0;
        if (pos < frame_px)
        begin
            if (item.op == OP_DRAIN)
                return 0;
            line_mem[pos % RING_DEPTH] = item.px;
        end
        in_col++;
        if (in_col >= w)
        begin
            in_col = 0;
            in_row++;
        end
        if (pos < lag || emitted >= frame_px)
            return 0;
        r = emitted / w;
        c = emitted % w;
        foreach (sum[ch])
            sum[ch] = 0;
        for (int ky = 0; ky < KERNEL_SIZE; ky++)
        begin
            ry = r + ky - HALF_K;
            if (ry < 0 || ry >= h)
                continue;
            for (int kx = 0; kx < KERNEL_SIZE; kx++)
            begin
                cx = c + kx - HALF_K;
                if (cx < 0 || cx >= w)
                    continue;
                tap = line_mem[(ry * w + cx) % RING_DEPTH];
                wt  = int'(BINOMIAL[ky]) * int'(BINOMIAL[kx]);
                for (int ch = 0; ch < NUM_CH; ch++)
                    sum[ch] += wt * int'(tap[ch]);
            end
        end
        for (int ch = 0; ch < NUM_CH; ch++)
            res.px[ch] = ((sum[ch] >> SUM_SHIFT) > 255) ? 8'hFF : CH_W'(sum[ch] >> SUM_SHIFT);
        emitted++;
        if (emitted == frame_px)
        begin
            res.frame_end = 1'b1;
            in_row  = 0;
            in_col  = 0;
            emitted = 0;
        end
        return 1;
    endfunction

    function automatic pixel_t random_pixel(input pixel_fill_t fill);
        pixel_t p;
        case (fill)
            FILL_WHITE: p = '1;
            FILL_BLACK: p = '0;
            default:
            begin
                p = $urandom;
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    case ($urandom_range(0, 7))
                        0:       p[ch] = '1;
                        1:       p[ch] = '0;
                        default: ;
                    endcase
                end
            end
        endcase
        return p;
    endfunction

    function automatic logic [DIM_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r < 12)
            return DIM_W'($urandom_range(1, 8));
        if (r < 18)
            return DIM_W'($urandom_range(9, 24));
        return DIM_W'($urandom_range(25, 48));
    endfunction

    function automatic logic [DIM_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0)
            return '0;
        if (r < 10)
            return DIM_W'($urandom_range(1, 6));
        return DIM_W'($urandom_range(7, 12));
    endfunction

    task automatic push_item(input opcode_t op, input pixel_t px);
        stream_item_t it;
        it.op = op;
        it.px = px;
        pixel_queue.push_back(it);
        items_pending++;
    endtask

    // frame pixels, with the odd drain item slipped in too early
    task automatic push_pixels(input int count, input pixel_fill_t fill);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                push_item(OP_DRAIN, random_pixel(FILL_RANDOM));
            push_item(OP_PIXEL, random_pixel(fill));
        end
    endtask

    // flush items, some of them pixels arriving after the frame
    task automatic push_drains(input int w);
        for (int i = 0; i < 2 * w + 2; i++)
            push_item(($urandom_range(0, 4) == 0) ? OP_PIXEL : OP_DRAIN,
                      random_pixel(FILL_RANDOM));
    endtask

    task automatic push_frame(input int w, input int h, input pixel_fill_t fill);
        push_pixels(w * h, fill);
        push_drains(w);
    endtask

    task automatic wait_idle();
        while (items_pending != 0 || writes_pending != 0 || expected_blur.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [DIM_W-1:0] value);
        reg_write_t wr;
        wr.index = index;
        wr.value = value;
        reg_queue.push_back(wr);
        writes_pending++;
        while (writes_pending != 0)
            @(posedge clk);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        write_register(REG_IMAGE_WIDTH, w);
        write_register(REG_IMAGE_HEIGHT, h);
    endtask

    // pixel sender, bursts with gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (predict_blur(item_on_bus, predicted))
                    expected_blur.push_back(predicted);
                items_pending--;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_queue.size() != 0)
                begin
                    item_on_bus = pixel_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item_on_bus.px;
                    s_axis_tuser  <= item_on_bus.op;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                apply_register(cfg_index, cfg_data);
                writes_pending--;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_queue.size() != 0)
                begin
                    write_on_bus = reg_queue.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= write_on_bus.index;
                    cfg_data  <= write_on_bus.value;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // result checker and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_blur.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result transfer: rgba %h last %b", got, m_axis_tlast);
                end
                else
                begin
                    wanted = expected_blur.pop_front();
                    if (got[0] !== wanted.px[0] || got[1] !== wanted.px[1] ||
                        got[2] !== wanted.px[2] || got[3] !== wanted.px[3] ||
                        m_axis_tlast !== wanted.frame_end)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("blur mismatch: expected rgba %h last %b, got rgba %h last %b",
                                     wanted.px, wanted.frame_end, got, m_axis_tlast);
                    end
                end
            end
            if (stall_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(16, 256);
            end
            else
                stall_left--;
            case (stall_mode)
                STALL_NONE:     m_axis_tready <= 1'b1;
                STALL_RANDOM:   m_axis_tready <= $urandom_range(0, 1);
                STALL_PERIODIC: m_axis_tready <= (cycle_count % 4 == 0);
                default:        m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("gaussian_blur_5x5_stream_tb: errors");
            $finish;
        end
    end

    initial
    begin
        int          w, h, frames, sel, n, random_items;
        bit          partial_open;
        pixel_fill_t fill;
        random_items = 0;
        partial_open = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single pixel frame
        set_dims(1, 1);
        push_item(OP_DRAIN, '1);
        push_item(OP_PIXEL, '1);
        push_item(OP_PIXEL, '0);
        push_item(OP_DRAIN, '1);
        push_item(OP_DRAIN, '0);
        push_item(OP_DRAIN, '1);
        wait_idle();
        set_dims(3, 3);
        push_frame(3, 3, FILL_WHITE);
        wait_idle();

        // clamped sizes
        set_dims(0, 0);
        push_frame(1, 1, FILL_RANDOM);
        wait_idle();
        set_dims(11'd2047, 1);
        push_frame(MAX_WIDTH, 1, FILL_WHITE);
        wait_idle();
        set_dims(1, 11'd2047);
        push_frame(1, MAX_HEIGHT, FILL_RANDOM);
        wait_idle();

        // spare index mid frame leaves the stream alone, a real write restarts it
        set_dims(4, 4);
        push_pixels(12, FILL_RANDOM);
        wait_idle();
        write_register(REG_SPARE_2, DIM_W'($urandom));
        push_pixels(4, FILL_RANDOM);
        push_drains(4);
        wait_idle();
        push_pixels(7, FILL_BLACK);
        wait_idle();
        write_register(REG_SPARE_3, DIM_W'($urandom));
        write_register(REG_IMAGE_WIDTH, 5);
        push_frame(5, 4, FILL_RANDOM);
        wait_idle();

        while (random_items < RANDOM_ITEMS)
        begin
            sel = partial_open ? 0 : $urandom_range(0, 3);
            if (sel == 0 || sel == 1)
                write_register(REG_IMAGE_WIDTH, pick_width());
            if (sel == 0 || sel == 2)
                write_register(REG_IMAGE_HEIGHT, pick_height());
            if ($urandom_range(0, 5) == 0)
                write_register(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                               DIM_W'($urandom));
            partial_open = 0;
            w = effective_dim(width_reg, MAX_WIDTH);
            h = effective_dim(height_reg, MAX_HEIGHT);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                case ($urandom_range(0, 9))
                    0:       fill = FILL_WHITE;
                    1:       fill = FILL_BLACK;
                    default: fill = FILL_RANDOM;
                endcase
                push_frame(w, h, fill);
                random_items += w * h + 2 * w + 2;
            end
            if (w * h > 1 && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, w * h - 1);
                push_pixels(n, FILL_RANDOM);
                random_items += n;
                partial_open = 1;
            end
            wait_idle();
        end

        wait_idle();
        if (mismatches == 0 && expected_blur.size() == 0)
            $display("gaussian_blur_5x5_stream_tb: clean");
        else
            $display("gaussian_blur_5x5_stream_tb: errors");
        $finish;
    end

endmodule
